@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER_AT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER_AT(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ sv/leei_pkg.sv @@
// ----------------------------------------------------------------------------
// Luminance edge error indicator package
// Shared constants, payload types, register codes and the half-sine table.
// ----------------------------------------------------------------------------
`default_nettype none
package leei_pkg;

  localparam int MAX_WIDTH        = 4096;
  localparam int MAX_HEIGHT       = 4096;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int DIM_W            = 13;
  localparam int STEP_W           = 16;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int COL_W            = $clog2(MAX_WIDTH);
  localparam int ROW_W            = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int ERR_W            = 64;
  localparam int WGT_W            = 40;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COL_STEP     = 3'd2,
    REG_ROW_STEP     = 3'd3,
    REG_SEQ_LEN      = 3'd4
  } leei_reg_e;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_CLIP, F_SQ, F_P4, F_P5, F_WGT, F_ACC
  } leei_front_e;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_SQ, B_QD, B_FV, B_CMP, B_SEQ, B_MDIV, B_OUT
  } leei_back_e;

  typedef struct packed {
    logic [7:0]  source_luma;
    logic [7:0]  degraded_luma;
    logic [10:0] source_edge;
    logic [10:0] degraded_edge;
  } leei_in_t;

  typedef struct packed {
    logic [15:0] frame_indicator;
    logic [15:0] sequence_indicator;
    logic        sequence_done;
  } leei_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [STEP_W-1:0] column_phase_step;
    logic [STEP_W-1:0] row_phase_step;
    logic [15:0]       sequence_length;
  } leei_cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0] err_sum;
    logic [WGT_W-1:0] wgt_sum;
  } leei_job_t;

  typedef struct packed {
    logic      valid;
    leei_job_t job;
  } leei_push_t;

  typedef struct packed {
    logic      valid;
    leei_job_t job;
  } leei_pop_t;

  typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    u   = 64'(k) * 64'(SINE_TABLE_DEPTH - k);
    num = u << 20;
    den = 64'(5) * 64'(SINE_TABLE_DEPTH) * 64'(SINE_TABLE_DEPTH) - 64'(4) * u;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/leei_front.sv @@
// ----------------------------------------------------------------------------
// Front stage
// Accepts pixels, forms the clipped error power and window weight, keeps
// the raster position and frame sums, and queues a job at each frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module leei_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire leei_pkg::leei_cfg_t cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire leei_pkg::leei_in_t  in_data_i,
  input  wire logic                q_full_i,
  output leei_pkg::leei_push_t     push_o
);
  import leei_pkg::*;

  localparam int NUM_W = 26;
  localparam int A_W   = 14;
  localparam logic [A_W-1:0] A_MAX = 14'd10240;
  localparam sine_rom_t SINE_ROM = build_sine();

  leei_front_e state_q, state_d;

  logic [COL_W-1:0]  cc_q;
  logic [ROW_W-1:0]  rc_q;
  logic [15:0]       cph_q, rph_q;
  logic [ERR_W-1:0]  err_q;
  logic [WGT_W-1:0]  wgt_q;

  logic [NUM_W-1:0]  num_q;
  logic [11:0]       den_q, rem_q;
  logic [4:0]        cnt_q;
  logic [A_W-1:0]    a_q;
  logic [27:0]       a2_q;
  logic [39:0]       a4_q;
  logic [37:0]       p5_q, ctr_q;
  logic [15:0]       w_q, sin_col_q, sin_row_q;

  logic [7:0]        ds, dp, dev;
  logic [10:0]       diff;
  logic [12:0]       rem_sh;
  logic              ge;
  logic [WCMP_W-1:0] wd;
  logic [HCMP_W-1:0] ht;
  logic              col_end, row_end, frame_end, accept;
  logic [ERR_W-1:0]  err_new;
  logic [WGT_W-1:0]  wgt_new;

  always_comb begin
    ds   = (in_data_i.source_luma > 8'd100) ? in_data_i.source_luma - 8'd100
                                            : 8'd100 - in_data_i.source_luma;
    dp   = (in_data_i.degraded_luma > 8'd100) ? in_data_i.degraded_luma - 8'd100
                                              : 8'd100 - in_data_i.degraded_luma;
    dev  = (ds > dp) ? ds : dp;
    diff = (in_data_i.degraded_edge > in_data_i.source_edge)
         ? in_data_i.degraded_edge - in_data_i.source_edge
         : in_data_i.source_edge - in_data_i.degraded_edge;
    rem_sh = {rem_q, num_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (cfg_i.frame_width == '0) begin
      wd = WCMP_W'(1);
    end else if (WCMP_W'(cfg_i.frame_width) > WCMP_W'(MAX_WIDTH)) begin
      wd = WCMP_W'(MAX_WIDTH);
    end else begin
      wd = WCMP_W'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      ht = HCMP_W'(1);
    end else if (HCMP_W'(cfg_i.frame_height) > HCMP_W'(MAX_HEIGHT)) begin
      ht = HCMP_W'(MAX_HEIGHT);
    end else begin
      ht = HCMP_W'(cfg_i.frame_height);
    end
    col_end   = (WCMP_W'(cc_q) + WCMP_W'(1)) >= wd;
    row_end   = (HCMP_W'(rc_q) + HCMP_W'(1)) >= ht;
    frame_end = col_end && row_end;
    err_new   = err_q + ERR_W'(ctr_q);
    wgt_new   = wgt_q + WGT_W'(w_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_DIV;
      F_DIV:  if (cnt_q == '0) state_d = F_CLIP;
      F_CLIP: state_d = F_SQ;
      F_SQ:   state_d = F_P4;
      F_P4:   state_d = F_P5;
      F_P5:   state_d = F_WGT;
      F_WGT:  state_d = F_ACC;
      F_ACC:  if (!(frame_end && q_full_i)) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != F_IDLE);
    accept           = in_valid_i && (state_q == F_IDLE);
    push_o.valid     = (state_q == F_ACC) && frame_end && !q_full_i;
    push_o.job.err_sum = err_new;
    push_o.job.wgt_sum = wgt_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cc_q    <= '0;
      rc_q    <= '0;
      cph_q   <= '0;
      rph_q   <= '0;
      err_q   <= '0;
      wgt_q   <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == F_ACC) && !(frame_end && q_full_i)) begin
        if (col_end) begin
          cc_q  <= '0;
          cph_q <= '0;
          if (row_end) begin
            rc_q  <= '0;
            rph_q <= '0;
            err_q <= '0;
            wgt_q <= '0;
          end else begin
            rc_q  <= rc_q + ROW_W'(1);
            rph_q <= rph_q + cfg_i.row_phase_step;
            err_q <= err_new;
            wgt_q <= wgt_new;
          end
        end else begin
          cc_q  <= cc_q + COL_W'(1);
          cph_q <= cph_q + cfg_i.column_phase_step;
          err_q <= err_new;
          wgt_q <= wgt_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sin_col_q <= SINE_ROM[cph_q[15 -: SINE_AW]];
    sin_row_q <= SINE_ROM[rph_q[15 -: SINE_AW]];
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          num_q <= NUM_W'(diff) * NUM_W'(20480);
          den_q <= 12'(in_data_i.source_edge) + 12'd80 + 12'(dev);
          rem_q <= '0;
          cnt_q <= 5'(NUM_W - 1);
        end
      end
      F_DIV: begin
        rem_q <= ge ? 12'(rem_sh - {1'b0, den_q}) : rem_sh[11:0];
        num_q <= {num_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - 5'd1;
      end
      F_CLIP: a_q <= (num_q > NUM_W'(A_MAX)) ? A_MAX : num_q[A_W-1:0];
      F_SQ: begin
        a2_q <= 28'(a_q) * 28'(a_q);
        w_q  <= 16'((32'(sin_col_q) * 32'(sin_row_q)) >> 16);
      end
      F_P4:  a4_q  <= 40'((56'(a2_q) * 56'(a2_q)) >> 16);
      F_P5:  p5_q  <= 38'((54'(a4_q) * 54'(a_q)) >> 16);
      F_WGT: ctr_q <= 38'((54'(p5_q) * 54'(w_q)) >> 16);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/leei_queue.sv @@
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of frame sums between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none
module leei_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire leei_pkg::leei_push_t push_i,
  output logic                      full_o,
  output leei_pkg::leei_pop_t       pop_o,
  input  wire logic                 take_i
);
  import leei_pkg::*;

  leei_job_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_pop;

  always_comb begin
    full_o      = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
    pop_o.valid = (cnt_q != '0);
    pop_o.job   = mem_q[rd_q];
    do_pop      = take_i && pop_o.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop) rd_q <= rd_q + QPTR_W'(1);
      if (push_i.valid && !do_pop) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (!push_i.valid && do_pop) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.job;
  end

endmodule
`default_nettype wire

@@ sv/leei_back.sv @@
// ----------------------------------------------------------------------------
// Back stage
// Takes the frame sums, forms the fifth root of their ratio (zero for a zero
// weight sum), keeps the sequence mean, and holds the result item in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module leei_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire leei_pkg::leei_cfg_t cfg_i,
  input  wire leei_pkg::leei_pop_t pop_i,
  output logic                     take_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output leei_pkg::leei_out_t      out_data_o
);
  import leei_pkg::*;

  localparam int FRAC_SH = 42;
  localparam int Q_W     = ERR_W + FRAC_SH;

  leei_back_e state_q, state_d;

  logic [Q_W-1:0]   q_q;
  logic [WGT_W-1:0] w_q, rem_q;
  logic [6:0]       cnt_q;
  logic [15:0]      f_q, c_q;
  logic [3:0]       b_q;
  logic [31:0]      c2_q;
  logic [63:0]      c4_q;
  logic [79:0]      c5_q;
  logic [31:0]      isum_q, md_q;
  logic [15:0]      fc_q;
  logic [16:0]      mrem_q, mden_q;
  logic             done_q, out_valid_q;
  leei_out_t        out_q;

  logic [WGT_W:0]   rem_sh;
  logic             ge;
  logic [17:0]      mrem_sh;
  logic             mge;
  logic [15:0]      cand, fc_new, len;
  logic [31:0]      isum_new;
  logic             seq_done, load;

  always_comb begin
    rem_sh   = {rem_q, q_q[Q_W-1]};
    ge       = rem_sh >= {1'b0, w_q};
    mrem_sh  = {mrem_q, md_q[31]};
    mge      = mrem_sh >= {1'b0, mden_q};
    cand     = f_q | (16'd1 << b_q);
    isum_new = isum_q + 32'(f_q);
    fc_new   = fc_q + 16'd1;
    len      = (cfg_i.sequence_length == '0) ? 16'd1 : cfg_i.sequence_length;
    seq_done = (fc_new == '0) || (fc_new >= len);
    load     = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_i.valid) state_d = (pop_i.job.wgt_sum == '0) ? B_SEQ : B_DIV;
      end
      B_DIV:  if (cnt_q == '0) state_d = B_SQ;
      B_SQ:   state_d = B_QD;
      B_QD:   state_d = B_FV;
      B_FV:   state_d = B_CMP;
      B_CMP:  state_d = (b_q == '0) ? B_SEQ : B_SQ;
      B_SEQ:  state_d = seq_done ? B_MDIV : B_OUT;
      B_MDIV: if (cnt_q == '0) state_d = B_OUT;
      B_OUT:  if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    take_o      = (state_q == B_IDLE);
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      isum_q      <= '0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_SEQ) begin
        isum_q <= seq_done ? '0 : isum_new;
        fc_q   <= seq_done ? '0 : fc_new;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.frame_indicator    <= f_q;
      out_q.sequence_indicator <= md_q[15:0];
      out_q.sequence_done      <= done_q;
    end
    case (state_q)
      B_IDLE: begin
        q_q   <= {pop_i.job.err_sum, {FRAC_SH{1'b0}}};
        w_q   <= pop_i.job.wgt_sum;
        rem_q <= '0;
        cnt_q <= 7'(Q_W - 1);
        f_q   <= '0;
        b_q   <= 4'd15;
      end
      B_DIV: begin
        rem_q <= ge ? WGT_W'(rem_sh - {1'b0, w_q}) : rem_sh[WGT_W-1:0];
        q_q   <= {q_q[Q_W-2:0], ge};
        cnt_q <= cnt_q - 7'd1;
      end
      B_SQ: begin
        c_q  <= cand;
        c2_q <= 32'(cand) * 32'(cand);
      end
      B_QD: c4_q <= 64'(c2_q) * 64'(c2_q);
      B_FV: c5_q <= 80'(c4_q) * 80'(c_q);
      B_CMP: begin
        if (Q_W'(c5_q) <= q_q) f_q <= c_q;
        b_q <= b_q - 4'd1;
      end
      B_SEQ: begin
        done_q <= seq_done;
        md_q   <= seq_done ? isum_new : '0;
        mrem_q <= '0;
        mden_q <= (fc_new == '0) ? 17'h10000 : {1'b0, fc_new};
        cnt_q  <= 7'd31;
      end
      B_MDIV: begin
        mrem_q <= mge ? 17'(mrem_sh - {1'b0, mden_q}) : mrem_sh[16:0];
        md_q   <= {md_q[30:0], mge};
        cnt_q  <= cnt_q - 7'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/luminance_edge_error_indicator_top.sv @@
// A pixel holds the front stage through a 26-step divider and six multiply and
// accumulate steps, and no new pixel is taken until it is through; a frame end
// holds it longer while it waits for room in the two-entry job queue. A
// frame-end job passes in the back stage through at most a 106-step ratio divider,
// a bitwise fifth-root search and a 32-step mean divider, plus any output stall.
// Reset clears the raster, frame and queue counters and the sums and loads the register defaults.
// ----------------------------------------------------------------------------
// Luminance edge error indicator
// Top level: configuration registers, front stage, job queue, back stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module luminance_edge_error_indicator_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire leei_pkg::leei_in_t                   in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output leei_pkg::leei_out_t                       out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [leei_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [leei_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import leei_pkg::*;

  leei_cfg_t  cfg_q;
  leei_push_t q_push;
  leei_pop_t  q_pop;
  logic       q_full, q_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width       <= DIM_W'(1920);
      cfg_q.frame_height      <= DIM_W'(1080);
      cfg_q.column_phase_step <= 16'd34;
      cfg_q.row_phase_step    <= 16'd61;
      cfg_q.sequence_length   <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (leei_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_q.frame_width       <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height      <= cfg_data_i[DIM_W-1:0];
        REG_COL_STEP:     cfg_q.column_phase_step <= cfg_data_i;
        REG_ROW_STEP:     cfg_q.row_phase_step    <= cfg_data_i;
        REG_SEQ_LEN:      cfg_q.sequence_length   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  leei_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push)
  );

  leei_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .pop_o  (q_pop),
    .take_i (q_take)
  );

  leei_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_i       (q_pop),
    .take_o      (q_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_AT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "front not busy after accept")
  `ASSERT_AT(a_push_idle, clk_i, rst_ni, q_push.valid |=> !in_stall_o, "front not idle after frame push")
  `ASSERT_NEVER_AT(a_seq_zero, clk_i, rst_ni, out_valid_o && !out_data_o.sequence_done && (out_data_o.sequence_indicator != '0), "sequence value without sequence end")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Luminance edge error indicator testbench
// Streams pixels through the block under several frame geometries, window
// steps and sequence lengths. The frame results are predicted in the bench
// and checked field by field, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import leei_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT  = 400;
  localparam int RANDOM_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  leei_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  leei_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  luminance_edge_error_indicator_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  leei_in_t pending_pixels[$];
  leei_out_t expected_frames[$];
  int errors = 0;
  int accepted_pixels = 0;
  int cycles = 0;

  // Mirror of the block's registers and accumulators.
  int unsigned width_reg, height_reg, col_step_reg, row_step_reg, seq_len_reg;
  int unsigned col_count, row_count, col_phase, row_phase, frame_count;
  logic [63:0] power_sum;
  logic [39:0] weight_sum;
  logic [31:0] indicator_total;

  function automatic longint unsigned half_sine_of(int unsigned phase);
    longint unsigned k, u, v;
    k = ((longint'(phase) & 64'hFFFF) * SINE_TABLE_DEPTH) >> 16;
    u = k * (SINE_TABLE_DEPTH - k);
    v = (u << 20) / (64'd5 * SINE_TABLE_DEPTH * SINE_TABLE_DEPTH - 64'd4 * u);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic logic [15:0] fifth_root_of(logic [63:0] e, logic [39:0] w);
    logic [127:0] ratio, pw;
    logic [15:0] f;
    logic [15:0] c;
    f = '0;
    if (w == 0) return '0;
    ratio = ({64'd0, e} << 42) / {88'd0, w};
    for (int b = 15; b >= 0; b--) begin
      c = f | (16'd1 << b);
      pw = 128'(c);
      pw = pw * c * c * c * c;
      if (pw <= ratio) f = c;
    end
    return f;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  task automatic predict_pixel(leei_in_t px);
    longint unsigned ds, dp, dev, diff, a, a2, a4, p5, w;
    int unsigned wd, ht, len;
    leei_out_t frame;
    ds = (px.source_luma > 100) ? px.source_luma - 100 : 100 - px.source_luma;
    dp = (px.degraded_luma > 100) ? px.degraded_luma - 100 : 100 - px.degraded_luma;
    dev = (ds > dp) ? ds : dp;
    diff = (px.degraded_edge > px.source_edge) ? px.degraded_edge - px.source_edge
                                               : px.source_edge - px.degraded_edge;
    a = (diff * 20480) / (px.source_edge + 80 + dev);
    if (a > 10240) a = 10240;
    a2 = a * a;
    a4 = (a2 * a2) >> 16;
    p5 = (a4 * a) >> 16;
    w = (half_sine_of(col_phase) * half_sine_of(row_phase)) >> 16;
    power_sum = power_sum + ((p5 * w) >> 16);
    weight_sum = weight_sum + w[39:0];
    wd = clamp_dim(width_reg, MAX_WIDTH);
    ht = clamp_dim(height_reg, MAX_HEIGHT);
    if (col_count + 1 < wd) begin
      col_count++;
      col_phase = (col_phase + col_step_reg) & 32'hFFFF;
      return;
    end
    col_count = 0;
    col_phase = 0;
    if (row_count + 1 < ht) begin
      row_count++;
      row_phase = (row_phase + row_step_reg) & 32'hFFFF;
      return;
    end
    row_count = 0;
    row_phase = 0;
    frame.frame_indicator = fifth_root_of(power_sum, weight_sum);
    frame.sequence_indicator = '0;
    frame.sequence_done = 1'b0;
    len = (seq_len_reg == 0) ? 1 : seq_len_reg;
    power_sum = '0;
    weight_sum = '0;
    indicator_total = indicator_total + 32'(frame.frame_indicator);
    frame_count = (frame_count + 1) & 32'hFFFF;
    if (frame_count == 0 || frame_count >= len) begin
      frame.sequence_indicator =
        16'(indicator_total / ((frame_count == 0) ? 65536 : frame_count));
      frame.sequence_done = 1'b1;
      indicator_total = '0;
      frame_count = 0;
    end
    expected_frames.push_back(frame);
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Sender: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic taken;
    leei_in_t px;
    taken = in_valid && !in_stall;
    if (taken) begin
      predict_pixel(in_data);
      accepted_pixels++;
    end
    if (!in_valid || taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        px = pending_pixels.pop_front();
        in_data <= px;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern with modes, plus one long hold-off.
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  always @(posedge clk) begin
    leei_out_t want;
    cycles++;
    if (out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report("unexpected frame result", 32'(out_data.frame_indicator), 0);
      end else begin
        want = expected_frames.pop_front();
        if (out_data.frame_indicator !== want.frame_indicator)
          report("frame_indicator", 32'(out_data.frame_indicator),
                 32'(want.frame_indicator));
        if (out_data.sequence_indicator !== want.sequence_indicator)
          report("sequence_indicator", 32'(out_data.sequence_indicator),
                 32'(want.sequence_indicator));
        if (out_data.sequence_done !== want.sequence_done)
          report("sequence_done", 32'(out_data.sequence_done),
                 32'(want.sequence_done));
      end
    end
    if (!hold_done && accepted_pixels >= 400) begin
      hold_done = 1'b1;
      hold_left = 8000;
    end
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(leei_reg_e idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_FRAME_WIDTH: width_reg = 32'(value & 16'h1FFF);
      REG_FRAME_HEIGHT: height_reg = 32'(value & 16'h1FFF);
      REG_COL_STEP: col_step_reg = 32'(value);
      REG_ROW_STEP: row_step_reg = 32'(value);
      default: seq_len_reg = 32'(value);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int unsigned wd, int unsigned ht, int unsigned cs,
                           int unsigned rs, int unsigned sl);
    write_reg(REG_FRAME_WIDTH, 16'(wd));
    write_reg(REG_FRAME_HEIGHT, 16'(ht));
    write_reg(REG_COL_STEP, 16'(cs));
    write_reg(REG_ROW_STEP, 16'(rs));
    write_reg(REG_SEQ_LEN, 16'(sl));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pixels.size() > 0 || in_valid || expected_frames.size() > 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic leei_in_t pixel(int s, int p, int se, int pe);
    leei_in_t px;
    px.source_luma = 8'(s);
    px.degraded_luma = 8'(p);
    px.source_edge = 11'(se);
    px.degraded_edge = 11'(pe);
    return px;
  endfunction

  function automatic leei_in_t random_pixel();
    leei_in_t px;
    px = pixel($urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 2047), $urandom_range(0, 2047));
    if ($urandom_range(0, 1) == 0)
      px.degraded_edge = 11'(32'(px.source_edge) + $urandom_range(0, 60));
    return px;
  endfunction

  initial begin
    int sent;
    int n;
    width_reg = 1920; height_reg = 1080; col_step_reg = 34; row_step_reg = 61;
    seq_len_reg = 300;
    col_count = 0; row_count = 0; col_phase = 0; row_phase = 0; frame_count = 0;
    power_sum = '0; weight_sum = '0; indicator_total = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    configure(3, 2, 21845, 32768, 2);
    pending_pixels.push_back(pixel(0, 0, 0, 0));
    pending_pixels.push_back(pixel(255, 255, 2047, 2047));
    pending_pixels.push_back(pixel(100, 100, 0, 2047));
    pending_pixels.push_back(pixel(100, 100, 2047, 0));
    pending_pixels.push_back(pixel(0, 255, 0, 2047));
    pending_pixels.push_back(pixel(255, 0, 10, 40));
    pending_pixels.push_back(pixel(100, 100, 5, 0));
    pending_pixels.push_back(pixel(99, 101, 300, 350));
    pending_pixels.push_back(pixel(128, 64, 1024, 1));
    pending_pixels.push_back(pixel(100, 100, 0, 1));
    pending_pixels.push_back(pixel(170, 85, 682, 1365));
    pending_pixels.push_back(pixel(255, 255, 0, 2047));
    wait_idle();

    // Single-pixel frames at phase zero have zero window weight.
    configure(1, 1, 65535, 65535, 3);
    for (int i = 0; i < 3; i++) pending_pixels.push_back(pixel(0, 255, 0, 2047));
    wait_idle();

    // Oversized geometry left mid-row, then shrunk under the open row.
    configure(16'hFFFF, 8191, 65535, 1, 65535);
    for (int i = 0; i < 20; i++) pending_pixels.push_back(random_pixel());
    wait_idle();
    configure(2, 1, 1, 1, 65535);
    for (int i = 0; i < 5; i++) pending_pixels.push_back(random_pixel());
    wait_idle();
    // Sequence length lowered after several frames of a long sequence.
    write_reg(REG_SEQ_LEN, 16'd1);
    for (int i = 0; i < 3; i++) pending_pixels.push_back(random_pixel());
    wait_idle();
    configure(4096, 1, 16, 1, 0);
    for (int i = 0; i < 6; i++) pending_pixels.push_back(random_pixel());
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      configure($urandom_range(1, 6), $urandom_range(1, 4),
                ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 65535),
                ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 65535),
                $urandom_range(1, 4));
      n = $urandom_range(20, 120);
      for (int i = 0; i < n; i++) pending_pixels.push_back(random_pixel());
      sent += n;
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/leei_pkg.sv
sv/leei_front.sv
sv/leei_queue.sv
sv/leei_back.sv
sv/luminance_edge_error_indicator_top.sv
tb/tb_top.sv
